### sv/gfe_pkg.sv
// ============================================================================
// gfe_pkg: shared definitions for the gated feedback echo
// Widths, reset values, register indexes and the lane control bundle.
// ============================================================================
`default_nettype none

package gfe_pkg;

    // Defaults for the top-level parameters.
    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ECHO_BITS     = 24;
    localparam int DECAY_BITS    = 16;
    localparam int LEN_BITS      = 12;
    localparam int INDEX_BITS    = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int NUM_LANES     = 2;

    // Register reset values.
    localparam logic [LEN_BITS-1:0]   SEL_LEN_RESET    = '0;
    localparam logic [LEN_BITS-1:0]   REP_LEN_RESET    = LEN_BITS'(1);
    localparam logic [INDEX_BITS-1:0] GATE_START_RESET = '0;
    localparam logic [DECAY_BITS-1:0] DECAY_RESET      = DECAY_BITS'(32768);
    localparam logic                  STEREO_RESET     = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SELECTION_LENGTH = 3'd0,
        REG_REPEAT_LENGTH    = 3'd1,
        REG_GATE_START       = 3'd2,
        REG_DECAY            = 3'd3,
        REG_STEREO           = 3'd4
    } cfg_reg_t;

    // Per-cycle control shared by all lanes.
    typedef struct packed {
        logic accept;    // a new frame enters; launch the delay-line reads
        logic advance;   // the frame in the compute stage moves on and is written back
        logic src_ok;    // the tap source of the computing frame may be echoed
        logic echo_ok;   // the feedback tap of the computing frame has been written
        logic sel_zero;  // selection length is zero: use the frame's own dry sample
        logic sel_one;   // selection length is one: use the previous frame's dry sample
        logic rep_one;   // repeat length is one: use the previous frame's echo
    } gfe_lane_ctl_t;

endpackage

`default_nettype wire

### sv/gfe_lane.sv
// ============================================================================
// gfe_lane: one channel of the feedback comb
// Holds the dry and echo delay lines of one channel and computes the
// rounded, saturated echo value for each frame.
// ============================================================================
`default_nettype none

module gfe_lane #(
    parameter int DELAY_DEPTH = gfe_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = gfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire  logic                                  aclk,
    input  wire  gfe_pkg::gfe_lane_ctl_t                ctl,
    input  wire  logic [$clog2(DELAY_DEPTH)-1:0]        rd_dry_addr,
    input  wire  logic [$clog2(DELAY_DEPTH)-1:0]        rd_echo_addr,
    input  wire  logic [$clog2(DELAY_DEPTH)-1:0]        wr_addr,
    input  wire  logic [gfe_pkg::DECAY_BITS-1:0]        decay,
    input  wire  logic signed [SAMPLE_BITS-1:0]         dry_in,
    output logic signed [SAMPLE_BITS-1:0]               dry_out,
    output logic signed [gfe_pkg::ECHO_BITS-1:0]        echo_out
);

    localparam int EB         = gfe_pkg::ECHO_BITS;
    localparam int DB         = gfe_pkg::DECAY_BITS;
    localparam int SUM_BITS   = ((SAMPLE_BITS > EB) ? SAMPLE_BITS : EB) + 1;
    localparam int PROD_BITS  = SUM_BITS + DB + 1;
    localparam int SHIFT_BITS = PROD_BITS - DB;

    localparam logic signed [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'(64'sd1 <<< (DB - 1));
    localparam logic signed [SHIFT_BITS-1:0] ECHO_HI    =
        SHIFT_BITS'((64'sd1 <<< (EB - 1)) - 64'sd1);
    localparam logic signed [SHIFT_BITS-1:0] ECHO_LO    = ~ECHO_HI;

    logic signed [SAMPLE_BITS-1:0] dry_mem [DELAY_DEPTH];
    logic signed [EB-1:0]          echo_mem [DELAY_DEPTH];

    logic signed [SAMPLE_BITS-1:0] rd_dry_reg;
    logic signed [EB-1:0]          rd_echo_reg;
    logic signed [SAMPLE_BITS-1:0] dry1_reg;
    logic signed [SAMPLE_BITS-1:0] dry2_reg;
    logic signed [EB-1:0]          echo2_reg;

    logic signed [SAMPLE_BITS-1:0] tap_dry;
    logic signed [EB-1:0]          tap_echo;
    logic signed [SUM_BITS-1:0]    loop_sum;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [PROD_BITS-1:0]   rounded;
    logic signed [SHIFT_BITS-1:0]  shifted;
    logic signed [EB-1:0]          echo_next;

    // Delay lines: one write port (compute stage) and one read port (accept).
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            dry_mem[wr_addr]  <= dry1_reg;
            echo_mem[wr_addr] <= echo_next;
        end
        if (ctl.accept) begin
            rd_dry_reg  <= dry_mem[rd_dry_addr];
            rd_echo_reg <= echo_mem[rd_echo_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            dry1_reg <= dry_in;
        end
        if (ctl.advance) begin
            dry2_reg  <= dry1_reg;
            echo2_reg <= echo_next;
        end
    end

    // The stage-two registers always hold the previous frame, so they stand in
    // for a delay-line read whose entry is written in the same cycle.
    always_comb begin
        if (!ctl.src_ok) begin
            tap_dry = '0;
        end else if (ctl.sel_zero) begin
            tap_dry = dry1_reg;
        end else if (ctl.sel_one) begin
            tap_dry = dry2_reg;
        end else begin
            tap_dry = rd_dry_reg;
        end

        if (!ctl.echo_ok) begin
            tap_echo = '0;
        end else if (ctl.rep_one) begin
            tap_echo = echo2_reg;
        end else begin
            tap_echo = rd_echo_reg;
        end
    end

    // Round to nearest with ties upward: floor((sum * decay + 2^15) / 2^16).
    always_comb begin
        loop_sum = SUM_BITS'(tap_dry) + SUM_BITS'(tap_echo);
        product  = PROD_BITS'(loop_sum) * PROD_BITS'($signed({1'b0, decay}));
        rounded  = product + ROUND_BIAS;
        shifted  = $signed(rounded[PROD_BITS-1:DB]);
        if (shifted > ECHO_HI) begin
            echo_next = EB'(ECHO_HI);
        end else if (shifted < ECHO_LO) begin
            echo_next = EB'(ECHO_LO);
        end else begin
            echo_next = EB'(shifted);
        end
    end

    assign dry_out  = dry2_reg;
    assign echo_out = echo2_reg;

endmodule

`default_nettype wire

### sv/gfe_merge.sv
// ============================================================================
// gfe_merge: output stage of the gated feedback echo
// Adds each lane's echo to its dry sample, saturates, and registers the frame.
// ============================================================================
`default_nettype none

module gfe_merge #(
    parameter int SAMPLE_BITS = gfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire  logic                               aclk,
    input  wire  logic                               load,
    input  wire  logic                               stereo,
    input  wire  logic signed [SAMPLE_BITS-1:0]      dry  [gfe_pkg::NUM_LANES],
    input  wire  logic signed [gfe_pkg::ECHO_BITS-1:0] echo [gfe_pkg::NUM_LANES],
    output logic signed [SAMPLE_BITS-1:0]            left_out,
    output logic signed [SAMPLE_BITS-1:0]            right_out
);

    localparam int EB       = gfe_pkg::ECHO_BITS;
    localparam int SUM_BITS = ((SAMPLE_BITS > EB) ? SAMPLE_BITS : EB) + 1;

    localparam logic signed [SUM_BITS-1:0] OUT_HI =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] OUT_LO = ~OUT_HI;

    logic signed [SUM_BITS-1:0]    mix  [gfe_pkg::NUM_LANES];
    logic signed [SAMPLE_BITS-1:0] clip [gfe_pkg::NUM_LANES];
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    always_comb begin
        for (int i = 0; i < gfe_pkg::NUM_LANES; i++) begin
            mix[i] = SUM_BITS'(dry[i]) + SUM_BITS'(echo[i]);
            if (mix[i] > OUT_HI) begin
                clip[i] = SAMPLE_BITS'(OUT_HI);
            end else if (mix[i] < OUT_LO) begin
                clip[i] = SAMPLE_BITS'(OUT_LO);
            end else begin
                clip[i] = SAMPLE_BITS'(mix[i]);
            end
        end
    end

    // In mono the right lane keeps running but its result is not shown.
    always_ff @(posedge aclk) begin
        if (load) begin
            left_out_reg  <= clip[0];
            right_out_reg <= stereo ? clip[1] : '0;
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

`default_nettype wire

### sv/gated_feedback_echo.sv
// ============================================================================
// gated_feedback_echo: stereo feedback-comb echo
// Path: an accepted input transaction passes the delay-line read and echo stage, then
// stage two, then the output register, whose load raises m_tvalid.
// Throughput: one frame per cycle, set by one read and one write per delay line per
// frame; the input stalls only when all three stages are full and the result waits.
// Reset: synchronous, active low; clears valid bits, registers and counters, and a
// fill count masks echo delay-line entries not yet written, so no clearing pass is run.
// ============================================================================
`default_nettype none

module gated_feedback_echo #(
    parameter int DELAY_DEPTH = gfe_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = gfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire  logic                                        aclk,
    input  wire  logic                                        aresetn,
    // Input frames. s_tdata: left_sample, right_sample (from bit 0 up).
    input  wire  logic                                        s_tvalid,
    output logic                                              s_tready,
    input  wire  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
    // Result frames. m_tdata: left_out, right_out (from bit 0 up).
    output logic                                              m_tvalid,
    input  wire  logic                                        m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]                m_tdata,
    // Configuration writes.
    input  wire  logic                                        cfg_valid,
    output logic                                              cfg_ready,
    input  wire  logic [gfe_pkg::CFG_ADDR_BITS-1:0]           cfg_index,
    input  wire  logic [gfe_pkg::CFG_DATA_BITS-1:0]           cfg_data
);

    localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int AW         = $clog2(DELAY_DEPTH);
    localparam int AW1        = AW + 1;
    localparam int LB         = gfe_pkg::LEN_BITS;
    localparam int IB         = gfe_pkg::INDEX_BITS;
    localparam int DB         = gfe_pkg::DECAY_BITS;
    localparam int NL         = gfe_pkg::NUM_LANES;

    localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must be issued only while the block is
    // idle; the block does not enforce this. The datapath reads these directly.
    // ------------------------------------------------------------------
    logic [LB-1:0] sel_len_reg;
    logic [LB-1:0] rep_len_reg;
    logic [IB-1:0] gate_start_reg;
    logic [DB-1:0] decay_reg;
    logic          stereo_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_len_reg    <= gfe_pkg::SEL_LEN_RESET;
            rep_len_reg    <= gfe_pkg::REP_LEN_RESET;
            gate_start_reg <= gfe_pkg::GATE_START_RESET;
            decay_reg      <= gfe_pkg::DECAY_RESET;
            stereo_reg     <= gfe_pkg::STEREO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (gfe_pkg::cfg_reg_t'(cfg_index))
                gfe_pkg::REG_SELECTION_LENGTH: sel_len_reg    <= cfg_data[LB-1:0];
                gfe_pkg::REG_REPEAT_LENGTH:    rep_len_reg    <= cfg_data[LB-1:0];
                gfe_pkg::REG_GATE_START:       gate_start_reg <= cfg_data[IB-1:0];
                gfe_pkg::REG_DECAY:            decay_reg      <= cfg_data[DB-1:0];
                gfe_pkg::REG_STEREO:           stereo_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Offsets longer than the delay line are held at its last entry. A zero
    // repeat length would make the loop read its own output, so it acts as one.
    function automatic logic [AW-1:0] clamp_len(input logic [LB-1:0] len);
        logic [AW-1:0] res;
        if (32'(len) > 32'(DELAY_DEPTH - 1)) begin
            res = LAST_POS;
        end else begin
            res = AW'(len);
        end
        return res;
    endfunction

    // Ring position d entries behind pos; the depth need not be a power of two.
    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                                input logic [AW-1:0] d);
        logic [AW1-1:0] res;
        if (pos >= d) begin
            res = {1'b0, pos} - {1'b0, d};
        end else begin
            res = AW1'(DELAY_DEPTH) + {1'b0, pos} - {1'b0, d};
        end
        return AW'(res);
    endfunction

    logic [LB-1:0] rep_len_eff;
    logic [AW-1:0] sel_off;
    logic [AW-1:0] rep_off;

    assign rep_len_eff = (rep_len_reg == '0) ? LB'(1) : rep_len_reg;
    assign sel_off     = clamp_len(sel_len_reg);
    assign rep_off     = clamp_len(rep_len_eff);

    // ------------------------------------------------------------------
    // Pipeline control. Stage one waits on the delay-line read data and
    // computes the echo, stage two holds the echo and the dry sample, and the
    // output register presents the merged frame. Each stage loads whenever the
    // stage after it is empty or moving, so the pipeline takes one frame a
    // cycle while results drain; s_tready drops only when all three stages
    // hold frames and the result waits on m_tready.
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic vo_reg;
    logic s_accept;
    logic s2_load;
    logic out_load;

    assign out_load = v2_reg && (!vo_reg || m_tready);
    assign s2_load  = v1_reg && (!v2_reg || out_load);
    assign s_tready = !v1_reg || s2_load;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = vo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (s2_load) begin
                v1_reg <= 1'b0;
            end
            if (s2_load) begin
                v2_reg <= 1'b1;
            end else if (out_load) begin
                v2_reg <= 1'b0;
            end
            if (out_load) begin
                vo_reg <= 1'b1;
            end else if (m_tready) begin
                vo_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame counters. The write position is shared by all delay lines. The
    // fill count tracks how many entries behind the write position hold real
    // data; an echo tap further back than that reads as zero, which stands in
    // for clearing the delay lines at reset. Dry taps need no such check:
    // the gate only passes sources that were already written.
    // ------------------------------------------------------------------
    logic [IB-1:0] frame_index_reg;
    logic [AW-1:0] wpos_reg;
    logic [AW-1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_index_reg <= '0;
            wpos_reg        <= '0;
            fill_reg        <= '0;
        end else if (s_accept) begin
            frame_index_reg <= frame_index_reg + IB'(1);
            wpos_reg        <= (wpos_reg == LAST_POS) ? '0 : wpos_reg + AW'(1);
            if (fill_reg != LAST_POS) begin
                fill_reg <= fill_reg + AW'(1);
            end
        end
    end

    // Source gate: the tap source index must exist, be above zero, and not
    // fall before gate_start.
    logic [IB-1:0] src_index;
    logic          src_ok_next;
    logic          echo_ok_next;

    assign src_index    = frame_index_reg - IB'(sel_off);
    assign src_ok_next  = (frame_index_reg >= IB'(sel_off)) && (src_index != '0)
                          && (src_index >= gate_start_reg);
    assign echo_ok_next = (rep_off <= fill_reg);

    logic [AW-1:0] waddr1_reg;
    logic          src_ok1_reg;
    logic          echo_ok1_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            waddr1_reg   <= wpos_reg;
            src_ok1_reg  <= src_ok_next;
            echo_ok1_reg <= echo_ok_next;
        end
    end

    gfe_pkg::gfe_lane_ctl_t lane_ctl;

    always_comb begin
        lane_ctl.accept   = s_accept;
        lane_ctl.advance  = s2_load;
        lane_ctl.src_ok   = src_ok1_reg;
        lane_ctl.echo_ok  = echo_ok1_reg;
        lane_ctl.sel_zero = (sel_off == '0);
        lane_ctl.sel_one  = (sel_off == AW'(1));
        lane_ctl.rep_one  = (rep_off == AW'(1));
    end

    // ------------------------------------------------------------------
    // Channel lanes. Left is lane 0, right is lane 1. In mono the right lane
    // is fed silence but keeps its delay lines running.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0]        lane_dry_in  [NL];
    logic signed [SAMPLE_BITS-1:0]        lane_dry_out [NL];
    logic signed [gfe_pkg::ECHO_BITS-1:0] lane_echo    [NL];

    assign lane_dry_in[0] = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign lane_dry_in[1] = stereo_reg ? $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;

    logic [AW-1:0] rd_dry_addr;
    logic [AW-1:0] rd_echo_addr;

    assign rd_dry_addr  = ring_back(wpos_reg, sel_off);
    assign rd_echo_addr = ring_back(wpos_reg, rep_off);

    for (genvar g = 0; g < NL; g++) begin : g_lane
        gfe_lane #(
            .DELAY_DEPTH (DELAY_DEPTH),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk         (aclk),
            .ctl          (lane_ctl),
            .rd_dry_addr  (rd_dry_addr),
            .rd_echo_addr (rd_echo_addr),
            .wr_addr      (waddr1_reg),
            .decay        (decay_reg),
            .dry_in       (lane_dry_in[g]),
            .dry_out      (lane_dry_out[g]),
            .echo_out     (lane_echo[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge: dry plus echo per channel, saturated, into the output register.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    gfe_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk      (aclk),
        .load      (out_load),
        .stereo    (stereo_reg),
        .dry       (lane_dry_out),
        .echo      (lane_echo),
        .left_out  (left_out),
        .right_out (right_out)
    );

    assign m_tdata = TDATA_BITS'({right_out, left_out});

endmodule

`default_nettype wire

### sv/gfe_checker.sv
// ============================================================================
// gfe_checker: port-level checks for the gated feedback echo
// Watches reset, stall-hold and the input-side ready while the output stage is free.
// ============================================================================
`default_nettype none

module gfe_checker #(
    parameter int SAMPLE_BITS = gfe_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata
);

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // When the output register is empty or draining, every stage can move,
    // so the input side must be ready.
    a_ready_when_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while the output side is free");

    // A stalled result stays and does not change.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind gated_feedback_echo gfe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### verif/gated_feedback_echo_tb.sv
// ============================================================================
// gated_feedback_echo_tb: self-checking testbench for the gated feedback echo
// Streams stereo frames through the block and checks every result transaction
// against a cycle-free model of the recursive comb: delay lines, gating,
// rounding, echo-store and output saturation, and mono operation.
// ============================================================================
`default_nettype none

module gated_feedback_echo_tb;

    localparam int DELAY_DEPTH = gfe_pkg::DELAY_DEPTH_DEF;
    localparam int SAMPLE_BITS = gfe_pkg::SAMPLE_BITS_DEF;
    localparam int LEN_BITS    = gfe_pkg::LEN_BITS;
    localparam int CFG_BITS    = gfe_pkg::CFG_DATA_BITS;
    localparam int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int STALL_LIMIT = 2000;   // cycles without any transaction
    localparam int MAX_REPORTS = 100;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS-1));
    localparam longint ECHO_MAX   = (64'sd1 <<< (gfe_pkg::ECHO_BITS-1)) - 1;
    localparam longint ECHO_MIN   = -(64'sd1 <<< (gfe_pkg::ECHO_BITS-1));

    typedef logic signed [SAMPLE_BITS-1:0]        sample_t;
    typedef logic signed [gfe_pkg::ECHO_BITS-1:0] echo_t;

    // One stereo frame as it sits in tdata: left in the low half.
    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_frame_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports.
    // ------------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;   // left_sample, right_sample (from bit 0 up)
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // left_out, right_out (from bit 0 up)
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    gfe_pkg::cfg_reg_t cfg_index = gfe_pkg::REG_SELECTION_LENGTH;
    logic [CFG_BITS-1:0] cfg_data = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gated_feedback_echo dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Model of the echo: its own copy of the registers and the delay lines.
    // ------------------------------------------------------------------------
    logic [LEN_BITS-1:0]            sel_len   = gfe_pkg::SEL_LEN_RESET;
    logic [LEN_BITS-1:0]            rep_len   = gfe_pkg::REP_LEN_RESET;
    logic [gfe_pkg::INDEX_BITS-1:0] gate_from = gfe_pkg::GATE_START_RESET;
    logic [gfe_pkg::DECAY_BITS-1:0] decay_q   = gfe_pkg::DECAY_RESET;
    logic                           stereo_on = gfe_pkg::STEREO_RESET;

    sample_t     dry_line  [2][DELAY_DEPTH] = '{default: '0};
    echo_t       echo_line [2][DELAY_DEPTH] = '{default: '0};
    int          ring_pos    = 0;
    logic [31:0] frame_count = '0;

    stereo_frame_t echo_outputs_due[$];

    int mismatch_count = 0;
    int src_idle_pct   = 0;   // chance in 100 that the sender idles a cycle
    int rx_stall_pct   = 0;   // chance in 100 that the receiver stalls a cycle
    int rx_hold_cycles = 0;   // a long receiver hold-off, counted down per cycle

    function automatic sample_t clip_sample(input longint v);
        if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
        return sample_t'(v);
    endfunction

    // One channel of the comb. The product is rounded half up by adding half
    // an LSB and flooring; the arithmetic shift floors negative values too.
    function automatic longint echo_lane(input int ch, input longint dry, input bit src_ok,
                                         input int unsigned sel, input int unsigned rep);
        longint tap;
        longint acc;
        longint e;
        tap = 0;
        if (src_ok)
            tap = (sel == 0) ? dry
                : longint'(dry_line[ch][(ring_pos + DELAY_DEPTH - sel) % DELAY_DEPTH]);
        acc = tap + longint'(echo_line[ch][(ring_pos + DELAY_DEPTH - rep) % DELAY_DEPTH]);
        e = (acc * longint'(decay_q) + 32768) >>> 16;
        if (e > ECHO_MAX) e = ECHO_MAX;
        if (e < ECHO_MIN) e = ECHO_MIN;
        dry_line[ch][ring_pos]  = sample_t'(dry);
        echo_line[ch][ring_pos] = echo_t'(e);
        return e;
    endfunction

    // Works out the result of one accepted frame and queues it.
    function automatic void predict_echo(input sample_t left_in, input sample_t right_in);
        int unsigned   sel;
        int unsigned   rep;
        logic [31:0]   src_index;
        bit            src_ok;
        longint        dry_l;
        longint        dry_r;
        longint        echo_l;
        longint        echo_r;
        stereo_frame_t want;
        sel = (sel_len > DELAY_DEPTH - 1) ? DELAY_DEPTH - 1 : sel_len;
        rep = (rep_len == 0) ? 1 : rep_len;
        if (rep > DELAY_DEPTH - 1) rep = DELAY_DEPTH - 1;
        // The tap source counts only if it exists, is not frame zero and is
        // not earlier than the gate.
        src_ok = 1'b0;
        if (frame_count >= sel) begin
            src_index = frame_count - sel;
            src_ok    = (src_index != 0) && (src_index >= gate_from);
        end
        dry_l  = longint'(left_in);
        dry_r  = stereo_on ? longint'(right_in) : 0;
        echo_l = echo_lane(0, dry_l, src_ok, sel, rep);
        echo_r = echo_lane(1, dry_r, src_ok, sel, rep);
        want.left  = clip_sample(dry_l + echo_l);
        want.right = stereo_on ? clip_sample(dry_r + echo_r) : '0;
        echo_outputs_due.push_back(want);
        ring_pos    = (ring_pos + 1) % DELAY_DEPTH;
        frame_count = frame_count + 32'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking of result transactions.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_output
        stereo_frame_t got;
        stereo_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2*SAMPLE_BITS-1:0];
            if (echo_outputs_due.size() == 0) begin
                report_mismatch("result with none pending (left)", 0, got.left);
            end else begin
                want = echo_outputs_due.pop_front();
                if (got.left !== want.left)
                    report_mismatch("left_out", want.left, got.left);
                if (got.right !== want.right)
                    report_mismatch("right_out", want.right, got.right);
            end
        end
    end

    // The receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready = 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // The run ends when no transaction of any kind has happened for too long.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("gated_feedback_echo_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Inputs change at the falling edge; handshakes are sampled at
    // the rising edge.
    // ------------------------------------------------------------------------
    task automatic send_frame(input sample_t left_in, input sample_t right_in);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;   // data without valid must be ignored
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {right_in, left_in};
        do @(posedge aclk); while (!s_tready);
        predict_echo(left_in, right_in);
    endtask

    task automatic write_reg(input gfe_pkg::cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gfe_pkg::REG_SELECTION_LENGTH: sel_len   = value[LEN_BITS-1:0];
            gfe_pkg::REG_REPEAT_LENGTH:    rep_len   = value[LEN_BITS-1:0];
            gfe_pkg::REG_GATE_START:       gate_from = value[gfe_pkg::INDEX_BITS-1:0];
            gfe_pkg::REG_DECAY:            decay_q   = value[gfe_pkg::DECAY_BITS-1:0];
            gfe_pkg::REG_STEREO:           stereo_on = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stops the sender and lets every pending result come out, so registers
    // change only when idle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (echo_outputs_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(SAMPLE_MAX);
            1:       return sample_t'(SAMPLE_MIN);
            2:       return sample_t'(int'($urandom_range(0, 128)) - 64);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Mostly short delays so echoes show up often, with the extremes mixed in.
    function automatic logic [CFG_BITS-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return (1 << LEN_BITS) - 1;
            2, 3:    return $urandom_range(1, (1 << LEN_BITS) - 2);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    task automatic randomize_config();
        logic [CFG_BITS-1:0] gate;
        logic [CFG_BITS-1:0] dec;
        case ($urandom_range(0, 5))
            3:       gate = frame_count + $urandom_range(0, 40);
            4:       gate = 32'hFFFF_FFFF;
            5:       gate = $urandom;
            default: gate = 0;
        endcase
        case ($urandom_range(0, 5))
            0:       dec = 0;
            1:       dec = 32'h0000_FFFF;
            2:       dec = 32'h0000_8000;
            default: dec = $urandom_range(0, 32'h0000_FFFF);
        endcase
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, pick_length());
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, pick_length());
        write_reg(gfe_pkg::REG_GATE_START, gate);
        write_reg(gfe_pkg::REG_DECAY, dec);
        write_reg(gfe_pkg::REG_STEREO, 32'($urandom_range(0, 3) != 0));
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: zero selection length, so from frame one the frame's own
    // sample feeds the echo at half gain. Frame zero is never echoed. The +1
    // and -1 samples of frame one land exactly on rounding ties.
    task automatic test_reset_state();
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sd1, -16'sd1);
        send_frame(-16'sd1, 16'sd1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(16'h5555), sample_t'(16'hAAAA));
        send_frame(sample_t'(16'hAAAA), sample_t'(16'h5555));
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    endtask

    task automatic test_special_cases();
        // A repeat length of zero behaves as one.
        wait_idle();
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, 0);
        send_frame(16'sd1000, -16'sd1000);
        send_frame(16'sd3, -16'sd3);
        // Taps from the previous frame's dry sample, repeats every third frame.
        wait_idle();
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, 1);
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, 3);
        send_frame(16'sd20000, -16'sd20000);
        send_frame(16'sd7, -16'sd7);
        send_frame(-16'sd9, 16'sd9);
        // Sources before the gate are not echoed; the gate opens mid-run.
        wait_idle();
        write_reg(gfe_pkg::REG_GATE_START, frame_count + 32'd2);
        repeat (4) send_frame(16'sd12000, -16'sd12000);
        // Mono: the right input is ignored and right_out stays zero.
        wait_idle();
        write_reg(gfe_pkg::REG_GATE_START, 0);
        write_reg(gfe_pkg::REG_STEREO, 0);
        send_frame(16'sd1234, sample_t'(SAMPLE_MAX));
        send_frame(-16'sd1234, sample_t'(SAMPLE_MIN));
        // Zero decay removes the echo entirely.
        wait_idle();
        write_reg(gfe_pkg::REG_STEREO, 1);
        write_reg(gfe_pkg::REG_DECAY, 0);
        send_frame(16'sd500, -16'sd500);
        // Longest delays: sources that lie before frame zero contribute nothing.
        wait_idle();
        write_reg(gfe_pkg::REG_DECAY, 32'h0000_FFFF);
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, (1 << LEN_BITS) - 1);
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, (1 << LEN_BITS) - 1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(-16'sd77, 16'sd77);
    endtask

    // Near-unity decay with a one-frame loop lets the echo grow until the
    // 24-bit store clips: positive on the left, negative on the right.
    task automatic test_echo_saturation();
        wait_idle();
        src_idle_pct = 0;
        rx_stall_pct = 0;
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, 1);
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, 1);
        write_reg(gfe_pkg::REG_GATE_START, 0);
        write_reg(gfe_pkg::REG_DECAY, 32'h0000_FFFF);
        write_reg(gfe_pkg::REG_STEREO, 1);
        repeat (270) send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        repeat (20) send_frame(pick_sample(), pick_sample());
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering frames, so the pipeline fills and s_tready must drop.
    task automatic test_backpressure();
        wait_idle();
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, 2);
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, 5);
        write_reg(gfe_pkg::REG_DECAY, 32'h0000_C000);
        src_idle_pct   = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 200;
        repeat (60) send_frame(pick_sample(), pick_sample());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        src_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        for (int sent = 0; sent < n_items; sent += 70) begin
            wait_idle();
            randomize_config();
            repeat (70) send_frame(pick_sample(), pick_sample());
        end
    endtask

    // Long taps reach several hundred frames back, far beyond the pipeline,
    // then the longest setting runs in mono.
    task automatic test_long_taps();
        wait_idle();
        src_idle_pct = 10;
        rx_stall_pct = 10;
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, 1000);
        write_reg(gfe_pkg::REG_REPEAT_LENGTH, 900);
        write_reg(gfe_pkg::REG_GATE_START, 0);
        write_reg(gfe_pkg::REG_DECAY, 32'd50000);
        write_reg(gfe_pkg::REG_STEREO, 1);
        repeat (100) send_frame(pick_sample(), pick_sample());
        wait_idle();
        write_reg(gfe_pkg::REG_SELECTION_LENGTH, (1 << LEN_BITS) - 1);
        write_reg(gfe_pkg::REG_STEREO, 0);
        repeat (50) send_frame(pick_sample(), pick_sample());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_special_cases();
        test_echo_saturation();
        test_backpressure();
        test_random_traffic(0, 0, 210);
        test_random_traffic(78, 0, 210);
        test_random_traffic(0, 78, 210);
        test_random_traffic(22, 22, 210);
        test_long_taps();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("gated_feedback_echo_tb OK");
        end else begin
            $display("gated_feedback_echo_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
